// ----- design/ott_pkg.sv -----
// ----------------------------------------------------------------------------
// ott_pkg: ordered timer table shared definitions
// Field widths, operation and status codes, and the cell interface types.
// ----------------------------------------------------------------------------
package ott_pkg;

   localparam int NUM_TIMERS_DEF = 32;
   localparam int OP_W           = 3;
   localparam int ID_W           = 6;
   localparam int EXP_ID_W       = 5;
   localparam int REM_W          = 24;
   localparam int STEP_W         = 16;
   localparam int STATUS_W       = 3;
   localparam logic [STEP_W-1:0] TICK_STEP_RST = STEP_W'(100);

   typedef enum logic [OP_W-1:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_TEST  = 3'd2,
      OP_TICK  = 3'd3,
      OP_POLL  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_BAD_ID       = 3'd1,
      ST_RUNNING      = 3'd2,
      ST_NOT_RUNNING  = 3'd3,
      ST_NONE_EXPIRED = 3'd4
   } status_type;

   // Update command for one cell.
   typedef struct packed {
      logic tick;    // lower remaining time by the step, clamp at zero
      logic shift;   // take the upper neighbor's contents
      logic load;    // append a new entry here
   } cell_cmd_type;

   // Contents of one cell, also handed to the lower neighbor.
   typedef struct packed {
      logic             valid;
      logic [ID_W-1:0]  id;
      logic [REM_W-1:0] remaining;
   } cell_data_type;

endpackage

// ----- design/ott_cell.sv -----
// ----------------------------------------------------------------------------
// ott_cell: one entry of the ordered timer list
// Holds id and remaining time, flags a match, ticks, shifts down or loads.
// ----------------------------------------------------------------------------
module ott_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  ott_pkg::cell_cmd_type          cmd,
   input  logic                           match_zero,
   input  logic [ott_pkg::ID_W-1:0]       cmp_id,
   input  logic [ott_pkg::REM_W-1:0]      load_rem,
   input  logic [ott_pkg::STEP_W-1:0]     tick_step,
   input  ott_pkg::cell_data_type         upper,
   output ott_pkg::cell_data_type         data,
   output logic                           hit
);

   logic                          valid_ff, valid_in;
   logic [ott_pkg::ID_W-1:0]      id_ff, id_in;
   logic [ott_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic                          hit_ff, hit_in;
   logic [ott_pkg::REM_W-1:0]     step_ext;

   assign step_ext = ott_pkg::REM_W'(tick_step);

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      rem_in   = rem_ff;
      priority if (cmd.shift) begin
         valid_in = upper.valid;
         id_in    = upper.id;
         rem_in   = upper.remaining;
      end else if (cmd.load) begin
         valid_in = 1'b1;
         id_in    = cmp_id;
         rem_in   = load_rem;
      end else if (cmd.tick) begin
         rem_in = (rem_ff > step_ext) ? rem_ff - step_ext : '0;
      end
      // match on a zero remaining time for poll, on the id otherwise
      hit_in = valid_ff & (match_zero ? (rem_ff == '0) : (id_ff == cmp_id));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      rem_ff <= rem_in;
   end

   assign data.valid     = valid_ff;
   assign data.id        = id_ff;
   assign data.remaining = rem_ff;
   assign hit            = hit_ff;

endmodule

// ----- design/ordered_timer_table.sv -----
// ----------------------------------------------------------------------------
// ordered_timer_table: ordered list of numbered countdown timers
// Start, stop, test, tick and poll over a row of cells kept in start order.
// ----------------------------------------------------------------------------
//
//  channel   ports                                  handshake
//  -------   -------------------------------------  -------------------------
//  request   req_op, req_timer_id, req_duration     start high, busy low
//  response  rsp_status, rsp_is_running,            rsp_valid, one cycle,
//            rsp_expired_valid, rsp_expired_id      cannot be held off
//  csr       csr_wr_data                            csr_wr_en
//
// A transaction passes through a compare cycle in which every cell flags a
// match, an update cycle in which the row ticks, appends or compacts, and the
// response cycle. busy is high for the compare and update cycles; the next
// transaction may start in the response cycle. The two-step pass over the cell
// row holds off a new request until the update is done.
// Reset empties the list and loads tick_step with 100.
// The receiver cannot stall: each response shows for one cycle only.
//
module ordered_timer_table #(
   parameter int NUM_TIMERS = ott_pkg::NUM_TIMERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ott_pkg::OP_W-1:0]      req_op,
   input  logic [ott_pkg::ID_W-1:0]      req_timer_id,
   input  logic [ott_pkg::REM_W-1:0]     req_duration,
   output logic                          rsp_valid,
   output logic [ott_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_is_running,
   output logic                          rsp_expired_valid,
   output logic [ott_pkg::EXP_ID_W-1:0]  rsp_expired_id,
   input  logic                          csr_wr_en,
   input  logic [ott_pkg::STEP_W-1:0]    csr_wr_data
);

   localparam int N    = NUM_TIMERS;
   localparam int ID_W = ott_pkg::ID_W;
   localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(NUM_TIMERS);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_MATCH = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type                       state_ff, state_in;
   logic [ott_pkg::OP_W-1:0]        op_ff, op_in;
   logic [ID_W-1:0]                 id_ff, id_in;
   logic [ott_pkg::REM_W-1:0]       dur_ff, dur_in;
   logic [ott_pkg::STEP_W-1:0]      step_ff, step_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ott_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic                            rsp_run_ff, rsp_run_in;
   logic                            rsp_exp_ff, rsp_exp_in;
   logic [ott_pkg::EXP_ID_W-1:0]    rsp_exp_id_ff, rsp_exp_id_in;

   ott_pkg::cell_cmd_type           cmd     [N];
   ott_pkg::cell_data_type          cdata   [N];
   ott_pkg::cell_data_type          cupper  [N];
   logic [N-1:0]                    hit;
   logic [N-1:0]                    vld;
   logic [N-1:0]                    neg_hit;
   logic [N-1:0]                    from_first;
   logic [N-1:0]                    first_hit;
   logic [N-1:0]                    append_at;
   logic                            any_hit;
   logic                            id_ok;
   logic                            match_zero;
   logic [ID_W-1:0]                 first_id;

   // ---------------------------------------------------------------------
   // Cell row: cell i hands its contents down to cell i-1 on a shift
   // ---------------------------------------------------------------------
   for (genvar g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_top
         assign cupper[g] = '0;
      end else begin : g_mid
         assign cupper[g] = cdata[g+1];
      end

      ott_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[g]),
         .match_zero (match_zero),
         .cmp_id     (id_ff),
         .load_rem   (dur_ff),
         .tick_step  (step_ff),
         .upper      (cupper[g]),
         .data       (cdata[g]),
         .hit        (hit[g])
      );

      assign vld[g] = cdata[g].valid;

      // append at the first free cell; occupied cells always form a prefix
      if (g == 0) begin : g_app0
         assign append_at[g] = ~vld[g];
      end else begin : g_appn
         assign append_at[g] = ~vld[g] & vld[g-1];
      end
   end

   // ---------------------------------------------------------------------
   // Match reduction: lowest hit and every cell from it upward
   // ---------------------------------------------------------------------
   assign match_zero = (op_ff == ott_pkg::OP_POLL);
   assign neg_hit    = ~hit + {{(N-1){1'b0}}, 1'b1};
   assign from_first = hit | neg_hit;
   assign first_hit  = hit & neg_hit;
   assign any_hit    = |hit;
   assign id_ok      = ({1'b0, id_ff} < ID_LIMIT);

   always_comb begin
      first_id = '0;
      for (int i = 0; i < N; i++) begin
         first_id = first_id | (cdata[i].id & {ID_W{first_hit[i]}});
      end
   end

   // ---------------------------------------------------------------------
   // Control: hold the request, run compare then update, drive response
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      dur_in        = dur_ff;
      step_in       = csr_wr_en ? csr_wr_data : step_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ott_pkg::ST_OK;
      rsp_run_in    = 1'b0;
      rsp_exp_in    = 1'b0;
      rsp_exp_id_in = '0;
      for (int i = 0; i < N; i++) begin
         cmd[i] = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_op;
               id_in    = req_timer_id;
               dur_in   = req_duration;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            unique case (op_ff)
               ott_pkg::OP_START: begin
                  if (!id_ok) begin
                     rsp_status_in = ott_pkg::ST_BAD_ID;
                  end else if (any_hit) begin
                     rsp_status_in = ott_pkg::ST_RUNNING;
                  end else begin
                     for (int i = 0; i < N; i++) begin
                        cmd[i].load = append_at[i];
                     end
                  end
               end
               ott_pkg::OP_STOP: begin
                  if (!id_ok) begin
                     rsp_status_in = ott_pkg::ST_BAD_ID;
                  end else if (!any_hit) begin
                     rsp_status_in = ott_pkg::ST_NOT_RUNNING;
                  end else begin
                     for (int i = 0; i < N; i++) begin
                        cmd[i].shift = from_first[i];
                     end
                  end
               end
               ott_pkg::OP_TEST: begin
                  rsp_run_in = id_ok & any_hit;
               end
               ott_pkg::OP_TICK: begin
                  for (int i = 0; i < N; i++) begin
                     cmd[i].tick = 1'b1;
                  end
               end
               ott_pkg::OP_POLL: begin
                  if (any_hit) begin
                     rsp_exp_in    = 1'b1;
                     rsp_exp_id_in = first_id[ott_pkg::EXP_ID_W-1:0];
                     for (int i = 0; i < N; i++) begin
                        cmd[i].shift = from_first[i];
                     end
                  end else begin
                     rsp_status_in = ott_pkg::ST_NONE_EXPIRED;
                  end
               end
               default: begin
                  // drop unused op codes; the response stays all zero
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ott_pkg::TICK_STEP_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      dur_ff        <= dur_in;
      rsp_status_ff <= rsp_status_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_exp_id_ff <= rsp_exp_id_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_is_running    = rsp_run_ff;
   assign rsp_expired_valid = rsp_exp_ff;
   assign rsp_expired_id    = rsp_exp_id_ff;

endmodule

// ----- design/ott_checker.sv -----
// ----------------------------------------------------------------------------
// ott_checker: port-level checks for the ordered timer table
// Watches the request and response ports over time.
// ----------------------------------------------------------------------------
module ott_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [ott_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_is_running,
   input logic                          rsp_expired_valid
);

   // every accepted transaction answers once the compare and update states are through
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing three cycles after accept");

   // busy covers the whole compare and update pass
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy ##1 busy)
      else $error("busy dropped during a transaction");

   // a response never overlaps work in flight
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // a removed expired timer always reports success
   a_expired_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_expired_valid) |->
         (rsp_status == ott_pkg::ST_OK && !rsp_is_running))
      else $error("expired timer with bad status");

endmodule

bind ordered_timer_table ott_checker u_ott_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_is_running    (rsp_is_running),
   .rsp_expired_valid (rsp_expired_valid)
);

// ----- tb/sv/tb_ordered_timer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_timer_table: self-checking bench for the ordered timer table
// Drives start, stop, test, tick and poll commands through the start/busy
// port, keeps its own copy of the timer list to predict every reply, and
// compares each reply field by field. Runs several tick_step settings,
// including both ends of the range and zero, with and without sender gaps.
// ----------------------------------------------------------------------------
module tb_ordered_timer_table;

   localparam int TIMER_SLOTS  = ott_pkg::NUM_TIMERS_DEF;
   localparam int DRAIN_CYCLES = 6;     // covers the compare/update/reply pipe
   localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all

   typedef struct {
      logic [ott_pkg::OP_W-1:0]  op;
      logic [ott_pkg::ID_W-1:0]  id;
      logic [ott_pkg::REM_W-1:0] dur;
   } timer_cmd_type;

   typedef struct {
      logic [ott_pkg::STATUS_W-1:0] status;
      logic                         running;
      logic                         exp_valid;
      logic [ott_pkg::EXP_ID_W-1:0] exp_id;
   } timer_reply_type;

   bit                           clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [ott_pkg::OP_W-1:0]     req_op;
   logic [ott_pkg::ID_W-1:0]     req_timer_id;
   logic [ott_pkg::REM_W-1:0]    req_duration;
   logic                         rsp_valid;
   logic [ott_pkg::STATUS_W-1:0] rsp_status;
   logic                         rsp_is_running;
   logic                         rsp_expired_valid;
   logic [ott_pkg::EXP_ID_W-1:0] rsp_expired_id;
   logic                         csr_wr_en;
   logic [ott_pkg::STEP_W-1:0]   csr_wr_data;

   ordered_timer_table #(.NUM_TIMERS(TIMER_SLOTS)) uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_timer_id      (req_timer_id),
      .req_duration      (req_duration),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_is_running    (rsp_is_running),
      .rsp_expired_valid (rsp_expired_valid),
      .rsp_expired_id    (rsp_expired_id),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Commands waiting to be driven, and replies owed by the block in order.
   timer_cmd_type   cmd_backlog[$];
   timer_reply_type replies_due[$];

   // Shadow copy of the timer list, kept in start order.
   logic [ott_pkg::ID_W-1:0]   list_id   [TIMER_SLOTS];
   logic [ott_pkg::REM_W-1:0]  list_left [TIMER_SLOTS];
   int                         list_len;
   logic [ott_pkg::STEP_W-1:0] step_now;

   int            idle_pct;        // chance in 100 that the sender skips a cycle
   bit            hs_fire;         // a transaction was taken at the last rising edge
   int            mismatch_count;
   int            stall_cycles;
   timer_cmd_type drive_cmd;

   task automatic report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Close the gap left by a removed entry, keeping the order of the rest.
   function automatic void drop_timer(int pos);
      for (int i = pos; i + 1 < list_len; i++) begin
         list_id[i]   = list_id[i + 1];
         list_left[i] = list_left[i + 1];
      end
      list_len--;
   endfunction

   // Apply one command to the shadow list and return the reply it earns.
   function automatic timer_reply_type run_timer_cmd(timer_cmd_type c);
      timer_reply_type r;
      int              pos;
      bit              id_ok;
      bit              found;
      r     = '{ott_pkg::ST_OK, 1'b0, 1'b0, '0};
      id_ok = (c.id < TIMER_SLOTS);
      pos   = -1;
      for (int i = 0; i < list_len; i++)
         if (pos < 0 && list_id[i] == c.id) pos = i;
      case (c.op)
         ott_pkg::OP_START: begin
            if (!id_ok) r.status = ott_pkg::ST_BAD_ID;
            else if (pos >= 0) r.status = ott_pkg::ST_RUNNING;   // keeps its old time
            else begin
               list_id[list_len]   = c.id;
               list_left[list_len] = c.dur;
               list_len++;
            end
         end
         ott_pkg::OP_STOP: begin
            if (!id_ok) r.status = ott_pkg::ST_BAD_ID;
            else if (pos < 0) r.status = ott_pkg::ST_NOT_RUNNING;
            else drop_timer(pos);
         end
         ott_pkg::OP_TEST: r.running = (pos >= 0);
         ott_pkg::OP_TICK: begin
            // clamp at zero; a zero step leaves every time alone
            for (int i = 0; i < list_len; i++)
               list_left[i] = (list_left[i] > step_now) ? list_left[i] - step_now : '0;
         end
         ott_pkg::OP_POLL: begin
            // hand back the oldest expired entry only
            r.status = ott_pkg::ST_NONE_EXPIRED;
            found    = 1'b0;
            for (int i = 0; i < list_len && !found; i++) begin
               if (list_left[i] == '0) begin
                  found       = 1'b1;
                  r.status    = ott_pkg::ST_OK;
                  r.exp_valid = 1'b1;
                  r.exp_id    = list_id[i][ott_pkg::EXP_ID_W-1:0];
                  drop_timer(i);
               end
            end
         end
         default: ;  // unused codes: no effect, all-zero reply
      endcase
      return r;
   endfunction

   task automatic queue_cmd(logic [ott_pkg::OP_W-1:0]  op,
                            logic [ott_pkg::ID_W-1:0]  id,
                            logic [ott_pkg::REM_W-1:0] dur);
      timer_cmd_type c;
      c.op  = op;
      c.id  = id;
      c.dur = dur;
      cmd_backlog.push_back(c);
   endtask

   // Durations scaled to the step so that timers really expire, plus the
   // extremes and fully random values to reach every duration bit.
   function automatic logic [ott_pkg::REM_W-1:0] pick_duration(int unsigned scale);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return '0;
      if (r < 15) return '1;
      if (r < 25) return ott_pkg::REM_W'($urandom);
      if (r < 40) return ott_pkg::REM_W'(scale * $urandom_range(1, 3) + $urandom_range(2) - 1);
      return ott_pkg::REM_W'($urandom_range(scale * 12));
   endfunction

   function automatic timer_cmd_type random_cmd(int unsigned scale);
      timer_cmd_type c;
      int unsigned   r;
      r = $urandom_range(99);
      if (r < 30)      c.op = ott_pkg::OP_START;
      else if (r < 40) c.op = ott_pkg::OP_STOP;
      else if (r < 50) c.op = ott_pkg::OP_TEST;
      else if (r < 73) c.op = ott_pkg::OP_TICK;
      else if (r < 95) c.op = ott_pkg::OP_POLL;
      else             c.op = ott_pkg::OP_W'($urandom_range(5, 7));
      c.id  = ($urandom_range(99) < 88) ? ott_pkg::ID_W'($urandom_range(TIMER_SLOTS - 1))
                                         : ott_pkg::ID_W'($urandom_range(TIMER_SLOTS, 63));
      c.dur = pick_duration(scale);
      return c;
   endfunction

   // Hold until every command is driven and answered, then let the pipe empty.
   task automatic wait_drained();
      do begin
         @(negedge clock);
         #1;
      end while (cmd_backlog.size() != 0 || start || replies_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_step(logic [ott_pkg::STEP_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= ott_pkg::STEP_W'($urandom);
   endtask

   task automatic random_phase(logic [ott_pkg::STEP_W-1:0] step, int count, int pct);
      int unsigned scale;
      scale    = (step == '0) ? 100 : step;
      idle_pct = pct;
      write_step(step);
      repeat (count) cmd_backlog.push_back(random_cmd(scale));
      wait_drained();
   endtask

   // Driver: present a new transaction once the previous one was taken,
   // or idle at random; hold everything while busy keeps a start waiting.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !hs_fire)) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
            drive_cmd    = cmd_backlog.pop_front();
            start        <= 1'b1;
            req_op       <= drive_cmd.op;
            req_timer_id <= drive_cmd.id;
            req_duration <= drive_cmd.dur;
         end else begin
            // drop start and scramble the fields, which must be ignored
            start        <= 1'b0;
            req_op       <= ott_pkg::OP_W'($urandom);
            req_timer_id <= ott_pkg::ID_W'($urandom);
            req_duration <= ott_pkg::REM_W'($urandom);
         end
      end
   end

   // Monitor: check the reply on the bus first (it belongs to an earlier
   // transaction), then predict the reply for a transaction taken now.
   always @(posedge clock) begin
      timer_cmd_type   c;
      timer_reply_type want;
      if (reset) begin
         list_len = 0;
         step_now = ott_pkg::TICK_STEP_RST;
         hs_fire  <= 1'b0;
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (replies_due.size() == 0) begin
               report($sformatf("reply with none outstanding, status %0d", rsp_status));
            end else begin
               want = replies_due.pop_front();
               if (rsp_status !== want.status)
                  report($sformatf("status %0d, expected %0d", rsp_status, want.status));
               if (rsp_is_running !== want.running)
                  report($sformatf("is_running %b, expected %b", rsp_is_running,
                                   want.running));
               if (rsp_expired_valid !== want.exp_valid)
                  report($sformatf("expired_valid %b, expected %b", rsp_expired_valid,
                                   want.exp_valid));
               if (rsp_expired_id !== want.exp_id)
                  report($sformatf("expired_id %0d, expected %0d", rsp_expired_id,
                                   want.exp_id));
            end
         end
         if (csr_wr_en) step_now = csr_wr_data;
         if (start && busy === 1'b0) begin
            c.op  = req_op;
            c.id  = req_timer_id;
            c.dur = req_duration;
            replies_due.push_back(run_timer_cmd(c));
            hs_fire <= 1'b1;
         end else begin
            hs_fire <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_op         = '0;
      req_timer_id   = '0;
      req_duration   = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      idle_pct       = 0;
      mismatch_count = 0;
      stall_cycles   = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pass at the reset step of 100.
      queue_cmd(ott_pkg::OP_TEST,  6'd0,  24'd0);        // empty list
      queue_cmd(ott_pkg::OP_POLL,  6'd0,  24'd0);        // nothing expired
      queue_cmd(ott_pkg::OP_STOP,  6'd5,  24'd0);        // not running
      queue_cmd(ott_pkg::OP_START, 6'd63, 24'hFFFFFF);   // bad ids
      queue_cmd(ott_pkg::OP_START, 6'd32, 24'd10);
      queue_cmd(ott_pkg::OP_STOP,  6'd40, 24'd0);
      queue_cmd(ott_pkg::OP_TEST,  6'd63, 24'd0);        // bad id tests as not running
      queue_cmd(ott_pkg::OP_START, 6'd0,  24'd0);        // zero duration: due at once
      queue_cmd(ott_pkg::OP_START, 6'd31, 24'hFFFFFF);
      queue_cmd(ott_pkg::OP_START, 6'd7,  24'd150);
      queue_cmd(ott_pkg::OP_START, 6'd0,  24'd999);      // already running, time kept
      queue_cmd(ott_pkg::OP_TEST,  6'd31, 24'd0);
      queue_cmd(ott_pkg::OP_POLL,  6'd0,  24'd0);
      queue_cmd(ott_pkg::OP_TICK,  6'd0,  24'd0);
      queue_cmd(ott_pkg::OP_TICK,  6'd0,  24'd0);        // clamps 7 at zero
      queue_cmd(ott_pkg::OP_POLL,  6'd0,  24'd0);
      queue_cmd(ott_pkg::OP_POLL,  6'd0,  24'd0);
      queue_cmd(ott_pkg::OP_STOP,  6'd31, 24'd0);
      queue_cmd(ott_pkg::OP_STOP,  6'd31, 24'd0);
      queue_cmd(ott_pkg::OP_START, 6'd3,  24'd101);      // expires after the one below
      queue_cmd(ott_pkg::OP_START, 6'd4,  24'd100);
      queue_cmd(ott_pkg::OP_TICK,  6'd0,  24'd0);
      queue_cmd(ott_pkg::OP_POLL,  6'd0,  24'd0);        // 4 first: 3 is older but not yet at zero
      queue_cmd(3'd5,              6'd42, 24'h5A5A5A);   // unused codes
      queue_cmd(3'd6,              6'd17, 24'hA5A5A5);
      queue_cmd(3'd7,              6'd63, 24'hFFFFFF);
      wait_drained();

      // Random phases over the step range, with and without sender gaps.
      random_phase(16'd1,     200, 0);
      random_phase(16'hFFFF,  200, 52);
      random_phase(16'd0,     120, 24);
      random_phase(ott_pkg::STEP_W'($urandom_range(2, 65534)), 250, 52);
      random_phase(ott_pkg::TICK_STEP_RST, 250, 0);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/ott_pkg.sv
design/ott_cell.sv
design/ordered_timer_table.sv
design/ott_checker.sv
tb/sv/tb_ordered_timer_table.sv
